FILE: rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// Lap timer leaderboard package
// Shared types and constants for the lap timer with sorted leaderboard.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int DEF_CAPACITY = 128;

  localparam int TIME_W   = 32;
  localparam int DRIVER_W = 16;
  localparam int SLOT_W   = 7;
  localparam int RANK_W   = 8;
  localparam int COUNT_W  = 8;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 168;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_INTERIM = 2'd1,
    REQ_RESET   = 2'd2,
    REQ_READ    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK,
    ST_SLOT,
    ST_FIN
  } state_t;

  typedef struct packed {
    req_kind_t           kind;
    logic [TIME_W-1:0]   timestamp;
    logic [SLOT_W-1:0]   slot;
  } req_t;

  typedef struct packed {
    logic [DRIVER_W-1:0] driver;
    logic [TIME_W-1:0]   split;
    logic [TIME_W-1:0]   lap;
  } entry_t;

  // Declared from the highest bit down so that lap_done lands in bit 0.
  typedef struct packed {
    logic [COUNT_W-1:0]  entry_count;
    logic [DRIVER_W-1:0] slot_driver;
    logic [TIME_W-1:0]   slot_split_time;
    logic [TIME_W-1:0]   slot_lap_time;
    logic                slot_valid;
    logic [TIME_W-1:0]   split_time;
    logic [RANK_W-1:0]   rank;
    logic [TIME_W-1:0]   lap_time;
    logic                lap_done;
  } res_t;

endpackage

FILE: rtl/lap_timer_sorted_leaderboard.sv
// ----------------------------------------------------------------------------
// Lap timer with sorted leaderboard
// Timing events in, one result item out per event; best laps kept sorted.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: the event kind in s_tuser, the time and
// the slot to read in s_tdata. Every accepted item produces exactly one result
// item on the m_ stream. The driver id register is written through cfg_we and
// cfg_wdata; the user must write it only while no event is in flight, as the
// block itself does not enforce this. The block works on one item at a time.
// An interim, a lap reset, a start without a completed lap and a read of an
// empty slot go straight to the result; a slot read first reads the board
// memory. A completed lap walks the board memory from its last entry toward
// the insertion point, one entry per cycle through the one read port and the
// one write port, over every stored entry with a longer lap time; on an empty
// board it writes the new entry straight to slot 0. s_tready rises again as
// the result is loaded.
// A finished result waits in the output register while the next item is
// already being processed; if the receiver stalls, that item finishes and
// then holds until the output register frees up.
// Reset clears the lap state, the driver id and the entry count, which empties
// the board at once; the memory itself needs no clearing.
// ----------------------------------------------------------------------------
module lap_timer_sorted_leaderboard
  import lts_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [DRIVER_W-1:0]  cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // timestamp[31:0], slot_index[38:32], zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // lap_done[0], lap_time[32:1], rank[40:33], split_time[72:41],
  // slot_valid[73], slot_lap_time[105:74], slot_split_time[137:106],
  // slot_driver[153:138], entry_count[161:154], zero fill
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  req_t          req;
  res_t          res_out;
  logic          done;
  logic          out_free;
  logic [CW-1:0] count;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  assign req.kind      = req_kind_t'(s_tuser);
  assign req.timestamp = s_tdata[TIME_W-1:0];
  assign req.slot      = s_tdata[TIME_W+SLOT_W-1:TIME_W];
  assign out_free      = !m_tvalid || m_tready;

  lts_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_tvalid),
    .req      (req),
    .ready    (s_tready),
    .out_free (out_free),
    .done     (done),
    .res_out  (res_out),
    .count    (count),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  lts_board_mem #(
    .CAPACITY(CAPACITY),
    .AW      (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {{(M_TDATA_W - $bits(res_t)){1'b0}}, res_out};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= (CW + 1)'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in progress");

  a_rank_needs_lap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[40:33] != 8'd0) |-> m_tdata[0])
    else $error("rank reported without a completed lap");

  a_lap_or_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[73]))
    else $error("lap result and slot read in the same item");

endmodule

FILE: rtl/lts_board_mem.sv
// ----------------------------------------------------------------------------
// Leaderboard memory
// One write port and one registered read port holding the sorted entries.
// ----------------------------------------------------------------------------
module lts_board_mem
  import lts_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lts_ctrl.sv
// ----------------------------------------------------------------------------
// Leaderboard controller
// Lap state, event decode and the insertion walk over the board memory.
// ----------------------------------------------------------------------------
module lts_ctrl
  import lts_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [DRIVER_W-1:0] cfg_wdata,
  input  logic                in_valid,
  input  req_t                req,
  output logic                ready,
  input  logic                out_free,
  output logic                done,
  output res_t                res_out,
  output logic [CW-1:0]       count,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output entry_t              mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  entry_t              mem_rdata
);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t              state, state_next;
  logic [CW-1:0]       pos;
  logic [TIME_W-1:0]   lap_start;
  logic [TIME_W-1:0]   lap_interim;
  logic                passed;
  logic [DRIVER_W-1:0] driver;
  entry_t              new_ent;
  res_t                res;
  logic                slot_hit;
  logic                shift;

  assign slot_hit = {{CW{1'b0}}, req.slot} < {{SLOT_W{1'b0}}, count};
  assign shift    = mem_rdata.lap > new_ent.lap;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next              = state;
    ready                   = 1'b0;
    done                    = 1'b0;
    mem_we                  = 1'b0;
    mem_waddr               = '0;
    mem_wdata               = new_ent;
    mem_re                  = 1'b0;
    mem_raddr               = '0;
    res_out                 = res;
    res_out.entry_count     = COUNT_W'(count);
    unique case (state)
      ST_IDLE: begin
        ready = 1'b1;
        if (in_valid) begin
          unique case (req.kind)
            REQ_START: state_next = passed ? ST_WALK_RD : ST_FIN;
            REQ_INTERIM, REQ_RESET: state_next = ST_FIN;
            REQ_READ: begin
              if (slot_hit) begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(req.slot);
                state_next = ST_SLOT;
              end else begin
                state_next = ST_FIN;
              end
            end
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_WALK_RD: begin
        if (pos == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          state_next = ST_FIN;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(pos - CW'(1));
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (shift) begin
          if (pos != CAP_C) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos);
            mem_wdata = mem_rdata;
          end
          if (pos != CW'(1)) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pos - CW'(2));
          end else begin
            state_next = ST_WALK_RD;
          end
        end else begin
          if (pos != CAP_C) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos);
          end
          state_next = ST_FIN;
        end
      end
      ST_SLOT: state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      lap_start   <= '0;
      lap_interim <= '0;
      passed      <= 1'b0;
      driver      <= '0;
    end else begin
      if (cfg_we) begin
        driver <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            pos <= count;
            unique case (req.kind)
              REQ_START: begin
                if (passed) begin
                  new_ent.lap    <= req.timestamp - lap_start;
                  new_ent.split  <= lap_interim - lap_start;
                  new_ent.driver <= driver;
                  res            <= '{lap_done: 1'b1,
                                      lap_time: req.timestamp - lap_start,
                                      default: '0};
                  lap_interim    <= '0;
                end else begin
                  res <= '0;
                end
                lap_start <= req.timestamp;
                passed    <= 1'b0;
              end
              REQ_INTERIM: begin
                lap_interim <= req.timestamp;
                passed      <= 1'b1;
                res         <= '{split_time: req.timestamp - lap_start, default: '0};
              end
              REQ_RESET: begin
                lap_start   <= '0;
                lap_interim <= '0;
                passed      <= 1'b0;
                res         <= '0;
              end
              REQ_READ: begin
                res <= '0;
              end
              default: begin
                res <= '0;
              end
            endcase
          end
        end
        ST_WALK_RD: begin
          if (pos == '0) begin
            res.rank <= RANK_W'(1);
            if (count != CAP_C) begin
              count <= count + CW'(1);
            end
          end
        end
        ST_WALK: begin
          if (shift) begin
            pos <= pos - CW'(1);
          end else if (pos != CAP_C) begin
            res.rank <= RANK_W'(pos) + RANK_W'(1);
            if (count != CAP_C) begin
              count <= count + CW'(1);
            end
          end
        end
        ST_SLOT: begin
          res.slot_valid      <= 1'b1;
          res.slot_lap_time   <= mem_rdata.lap;
          res.slot_split_time <= mem_rdata.split;
          res.slot_driver     <= mem_rdata.driver;
        end
        ST_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule
